>>> design/swmf_pkg.sv
// Shared types and constants of the square window median filter.
`timescale 1ns / 1ps
package swmf_pkg;

   localparam int LW_W       = 12;   // line_width register
   localparam int FH_W       = 13;   // frame_height register
   localparam int RAD_W      = 2;    // radius register
   localparam int ROW_W      = 12;   // row counter and result row
   localparam int COL_OUT_W  = 11;   // result column
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int NARROW_BITS = 8;
   localparam int MAX_HEIGHT  = 4096;

   localparam logic [LW_W-1:0]  LINE_WIDTH_RESET   = 12'd640;
   localparam logic [FH_W-1:0]  FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [RAD_W-1:0] RADIUS_RESET       = 2'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_RADIUS       = 2'd2,
      CSR_WIDE_SAMPLES = 2'd3
   } csr_index_type;

   // Position tag that travels with each pixel down the pipeline.
   typedef struct packed {
      logic [ROW_W-1:0]     row;
      logic [COL_OUT_W-1:0] col;
      logic                 last;
   } tag_type;

endpackage

>>> design/swmf_ram.sv
// Generic single-write, single-read RAM with a registered, read-first output.
`timescale 1ns / 1ps
module swmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/swmf_ctl.sv
// Raster position counters, line store addressing and result tagging.
`timescale 1ns / 1ps
module swmf_ctl import swmf_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_RADIUS = 3,
   localparam int CNT_W  = $clog2(MAX_WIDTH + 1),
   localparam int AW     = $clog2(MAX_WIDTH),
   localparam int MR_W   = $clog2(MAX_RADIUS + 1),
   localparam int SPAN_W = MR_W + 1,
   localparam int SLOTS  = 2 * MAX_RADIUS,
   localparam int SLOT_W = $clog2(SLOTS),
   localparam int SIDE   = SLOTS + 1,
   localparam int RANK_W = $clog2(SIDE * SIDE)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [LW_W-1:0]             line_width,
   input  logic [FH_W-1:0]             frame_height,
   input  logic [RAD_W-1:0]            radius,
   input  logic                        accept,
   output logic [AW-1:0]               col_addr,
   output logic [SLOT_W-1:0]           wr_slot,
   output logic [SPAN_W-1:0]           span,
   output logic [RANK_W-1:0]           target,
   output logic                        emit,
   output tag_type                     tag,
   output logic [SLOTS-1:0][SLOT_W-1:0] sel
);

   logic [CNT_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SLOT_W-1:0] mod_ff [MAX_RADIUS];
   logic [SLOT_W-1:0] mod_in [MAX_RADIUS];

   logic [CNT_W-1:0]  w_eff, col_eff;
   logic [FH_W-1:0]   h_eff;
   logic [ROW_W-1:0]  row_eff;
   logic [MR_W-1:0]   r_eff;
   logic              row_restart;
   logic [SLOT_W-1:0] base;

   always_comb begin
      if (line_width == '0) begin
         w_eff = CNT_W'(1);
      end else if (int'(line_width) > MAX_WIDTH) begin
         w_eff = CNT_W'(MAX_WIDTH);
      end else begin
         w_eff = CNT_W'(line_width);
      end
      if (frame_height == '0) begin
         h_eff = FH_W'(1);
      end else if (int'(frame_height) > MAX_HEIGHT) begin
         h_eff = FH_W'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height;
      end
      if (int'(radius) > MAX_RADIUS) begin
         r_eff = MR_W'(MAX_RADIUS);
      end else begin
         r_eff = MR_W'(radius);
      end
      span = {r_eff, 1'b0};

      // A counter left out of range by a register change restarts at zero.
      col_eff     = (col_ff >= w_eff) ? '0 : col_ff;
      row_restart = ({1'b0, row_ff} >= h_eff);
      row_eff     = row_restart ? '0 : row_ff;

      // Row modulo span picks the line store slot of the current row.
      base = '0;
      for (int i = 0; i < MAX_RADIUS; i++) begin
         if (int'(r_eff) == i + 1) begin
            base = row_restart ? '0 : mod_ff[i];
         end
      end
      for (int k = 0; k < SLOTS; k++) begin
         if (int'(base) + k >= int'(span)) begin
            sel[k] = SLOT_W'(int'(base) + k - int'(span));
         end else begin
            sel[k] = SLOT_W'(int'(base) + k);
         end
      end

      col_addr = col_eff[AW-1:0];
      wr_slot  = base;
      emit     = (int'(row_eff) >= int'(span)) && (int'(col_eff) >= int'(span));
      target   = RANK_W'(2 * int'(r_eff) * (int'(r_eff) + 1));
      tag.row  = ROW_W'(int'(row_eff) - int'(r_eff));
      tag.col  = COL_OUT_W'(int'(col_eff) - int'(r_eff));
      tag.last = (int'(row_eff) == int'(h_eff) - 1) && (int'(col_eff) == int'(w_eff) - 1);

      // Advance the raster position.
      col_in = col_eff + CNT_W'(1);
      row_in = row_eff;
      for (int i = 0; i < MAX_RADIUS; i++) begin
         mod_in[i] = row_restart ? '0 : mod_ff[i];
      end
      if (col_in >= w_eff) begin
         col_in = '0;
         if (int'(row_eff) + 1 >= int'(h_eff)) begin
            row_in = '0;
            for (int i = 0; i < MAX_RADIUS; i++) begin
               mod_in[i] = '0;
            end
         end else begin
            row_in = row_eff + ROW_W'(1);
            for (int i = 0; i < MAX_RADIUS; i++) begin
               if (int'(mod_in[i]) + 1 == 2 * (i + 1)) begin
                  mod_in[i] = '0;
               end else begin
                  mod_in[i] = mod_in[i] + SLOT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         for (int i = 0; i < MAX_RADIUS; i++) begin
            mod_ff[i] <= '0;
         end
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         for (int i = 0; i < MAX_RADIUS; i++) begin
            mod_ff[i] <= mod_in[i];
         end
      end
   end

endmodule

>>> design/swmf_median.sv
// Window shift registers and the pipelined rank-select median unit.
`timescale 1ns / 1ps
module swmf_median import swmf_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_RADIUS  = 3,
   localparam int SIDE   = 2 * MAX_RADIUS + 1,
   localparam int NW     = SIDE * SIDE,
   localparam int SPAN_W = $clog2(MAX_RADIUS + 1) + 1,
   localparam int RANK_W = $clog2(NW)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic                              in_emit,
   input  logic [SPAN_W-1:0]                 in_span,
   input  logic [RANK_W-1:0]                 in_target,
   input  tag_type                           in_tag,
   input  logic [SIDE-1:0][SAMPLE_BITS-1:0]  in_column,
   output logic                              out_valid,
   input  logic                              out_ready,
   output tag_type                           out_tag,
   output logic [SAMPLE_BITS-1:0]            out_median
);

   logic [SAMPLE_BITS-1:0] win_ff [SIDE][SIDE];

   logic              c_valid_ff;
   tag_type           c_tag_ff;
   logic [SPAN_W-1:0] c_span_ff;
   logic [RANK_W-1:0] c_target_ff;

   logic                   d_valid_ff;
   logic [NW-1:0]          lt_ff [NW];
   logic [NW-1:0]          lt_in [NW];
   logic [SAMPLE_BITS-1:0] d_val_ff [NW];
   tag_type                d_tag_ff;
   logic [RANK_W-1:0]      d_target_ff;

   logic                   out_valid_ff;
   tag_type                out_tag_ff;
   logic [SAMPLE_BITS-1:0] out_median_ff, out_median_in;

   logic [SAMPLE_BITS:0] key [NW];
   logic en_c, en_d, en_e;

   assign en_e     = !out_valid_ff || out_ready;
   assign en_d     = !d_valid_ff || en_e;
   assign en_c     = !c_valid_ff || en_d;
   assign in_ready = en_c;

   // Every pixel shifts the window, whether or not it yields a result.
   always_ff @(posedge clock) begin
      if (in_valid && en_c) begin
         for (int k = 0; k < SIDE; k++) begin
            for (int j = 0; j < SIDE - 1; j++) begin
               win_ff[k][j] <= win_ff[k][j+1];
            end
            win_ff[k][SIDE-1] <= in_column[k];
         end
         c_tag_ff    <= in_tag;
         c_span_ff   <= in_span;
         c_target_ff <= in_target;
      end
   end

   // Elements outside the active window get a set top bit so they rank above
   // every real sample; ties break by position, so ranks are all distinct.
   always_comb begin
      for (int k = 0; k < SIDE; k++) begin
         for (int j = 0; j < SIDE; j++) begin
            key[k*SIDE+j] = {!((k <= int'(c_span_ff)) && (j + int'(c_span_ff) >= SIDE - 1)),
                             win_ff[k][j]};
         end
      end
      for (int i = 0; i < NW; i++) begin
         for (int j = 0; j < NW; j++) begin
            lt_in[i][j] = (key[j] < key[i]) || ((key[j] == key[i]) && (j < i));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_valid_ff && en_d) begin
         for (int i = 0; i < NW; i++) begin
            lt_ff[i]    <= lt_in[i];
            d_val_ff[i] <= key[i][SAMPLE_BITS-1:0];
         end
         d_tag_ff    <= c_tag_ff;
         d_target_ff <= c_target_ff;
      end
   end

   always_comb begin
      out_median_in = '0;
      for (int i = 0; i < NW; i++) begin
         if ($countones(lt_ff[i]) == int'(d_target_ff)) begin
            out_median_in = out_median_in | d_val_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (d_valid_ff && en_e) begin
         out_tag_ff    <= d_tag_ff;
         out_median_ff <= out_median_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en_c) begin
            c_valid_ff <= in_valid && in_emit;
         end
         if (en_d) begin
            d_valid_ff <= c_valid_ff;
         end
         if (en_e) begin
            out_valid_ff <= d_valid_ff;
         end
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_tag    = out_tag_ff;
   assign out_median = out_median_ff;

endmodule

>>> design/square_window_median_filter_top.sv
// Top level of the square window median filter.
`timescale 1ns / 1ps
// The filter takes one pixel per clock in raster order, unless the result side
// stalls, and returns the median of the (2r+1) x (2r+1) window centered on
// each interior pixel, tagged with its row and column; border pixels within r
// of an edge give no result. Throughput, stalls aside, is one pixel per cycle.
// An accepted pixel reads the line store on the accepting edge, then passes
// the window shift, the pairwise compare stage, and the rank count that drives
// the output register. The line store is 2*MAX_RADIUS single-port-write RAMs
// of MAX_WIDTH entries, one per buffered row, all read at the current column
// on each accept. Registers must be written only between frames while idle.
module square_window_median_filter_top import swmf_pkg::*; #(
   parameter int MAX_WIDTH   = 2048,
   parameter int MAX_RADIUS  = 3,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_pixel_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ROW_W-1:0]       rsp_out_row,
   output logic [COL_OUT_W-1:0]   rsp_out_col,
   output logic [SAMPLE_BITS-1:0] rsp_median_value,
   output logic                   rsp_last_of_frame,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int MR_W   = $clog2(MAX_RADIUS + 1);
   localparam int SPAN_W = MR_W + 1;
   localparam int SLOTS  = 2 * MAX_RADIUS;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int SIDE   = SLOTS + 1;
   localparam int RANK_W = $clog2(SIDE * SIDE);

   logic [LW_W-1:0]  line_width_ff;
   logic [FH_W-1:0]  frame_height_ff;
   logic [RAD_W-1:0] radius_ff;
   logic             wide_samples_ff;

   logic                         accept;
   logic [AW-1:0]                col_addr;
   logic [SLOT_W-1:0]            wr_slot;
   logic [SPAN_W-1:0]            span;
   logic [RANK_W-1:0]            target;
   logic                         emit;
   tag_type                      tag;
   logic [SLOTS-1:0][SLOT_W-1:0] sel;
   logic [SAMPLE_BITS-1:0]       pixel;
   logic [SAMPLE_BITS-1:0]       ram_rd [SLOTS];

   logic                         b_valid_ff;
   logic [SAMPLE_BITS-1:0]       b_pixel_ff;
   logic [SLOTS-1:0][SLOT_W-1:0] b_sel_ff;
   logic [SPAN_W-1:0]            b_span_ff;
   logic [RANK_W-1:0]            b_target_ff;
   logic                         b_emit_ff;
   tag_type                      b_tag_ff;

   logic                          win_ready;
   logic [SIDE-1:0][SAMPLE_BITS-1:0] column;
   tag_type                       rsp_tag;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         radius_ff       <= RADIUS_RESET;
         wide_samples_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINE_WIDTH:   line_width_ff   <= csr_data[LW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[FH_W-1:0];
            CSR_RADIUS:       radius_ff       <= csr_data[RAD_W-1:0];
            CSR_WIDE_SAMPLES: wide_samples_ff <= csr_data[0];
            default:          ;
         endcase
      end
   end

   assign req_ready = !b_valid_ff || win_ready;
   assign accept    = req_valid && req_ready;
   assign pixel     = wide_samples_ff ? req_pixel_value
                                      : SAMPLE_BITS'(req_pixel_value[NARROW_BITS-1:0]);

   swmf_ctl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_ctl (
      .clock        (clock),
      .reset        (reset),
      .line_width   (line_width_ff),
      .frame_height (frame_height_ff),
      .radius       (radius_ff),
      .accept       (accept),
      .col_addr     (col_addr),
      .wr_slot      (wr_slot),
      .span         (span),
      .target       (target),
      .emit         (emit),
      .tag          (tag),
      .sel          (sel)
   );

   // The RAM holding the oldest buffered row is read and overwritten at the
   // same address in the same cycle; its read-first output returns the old row.
   for (genvar s = 0; s < SLOTS; s++) begin : g_line
      swmf_ram #(
         .WIDTH (SAMPLE_BITS),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (accept && (span != '0) && (int'(wr_slot) == s)),
         .wr_addr (col_addr),
         .wr_data (pixel),
         .rd_en   (accept),
         .rd_addr (col_addr),
         .rd_data (ram_rd[s])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (req_ready) begin
         b_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_pixel_ff  <= pixel;
         b_sel_ff    <= sel;
         b_span_ff   <= span;
         b_target_ff <= target;
         b_emit_ff   <= emit;
         b_tag_ff    <= tag;
      end
   end

   always_comb begin
      for (int k = 0; k < SIDE; k++) begin
         column[k] = b_pixel_ff;
         if (k < SLOTS) begin
            if (k < int'(b_span_ff)) begin
               column[k] = ram_rd[b_sel_ff[k]];
            end
         end
      end
   end

   swmf_median #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_RADIUS  (MAX_RADIUS)
   ) u_median (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (b_valid_ff),
      .in_ready   (win_ready),
      .in_emit    (b_emit_ff),
      .in_span    (b_span_ff),
      .in_target  (b_target_ff),
      .in_tag     (b_tag_ff),
      .in_column  (column),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_tag    (rsp_tag),
      .out_median (rsp_median_value)
   );

   assign rsp_out_row       = rsp_tag.row;
   assign rsp_out_col       = rsp_tag.col;
   assign rsp_last_of_frame = rsp_tag.last;

endmodule

>>> design/swmf_checker.sv
// Port-level checks for the square window median filter, bound to the top level.
`timescale 1ns / 1ps
module swmf_port_checks import swmf_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [ROW_W-1:0]       rsp_out_row,
   input logic [COL_OUT_W-1:0]   rsp_out_col,
   input logic [SAMPLE_BITS-1:0] rsp_median_value,
   input logic                   rsp_last_of_frame
);

   // A result transaction that is held back keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median_value)
         && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_last_of_frame))
      else $error("result changed while stalled");

   // With the result side open, no pipeline stage can block the input.
   a_ready_through: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output is ready");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

   // No result appears without a pixel transaction to produce it.
   a_no_result_after_idle: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && !$past(req_valid) && !$past(rsp_valid) && $past(rsp_ready)
         && !$past(req_valid, 2) && $past(rsp_ready, 2) && !$past(rsp_valid, 2)
         && !$past(req_valid, 3) && $past(rsp_ready, 3)
         && !$past(req_valid, 4) && $past(rsp_ready, 4)
         && !$past(req_valid, 5) && $past(rsp_ready, 5)
         && $past(!reset, 5) |-> !rsp_valid)
      else $error("result without a pixel transaction");

endmodule

bind square_window_median_filter_top swmf_port_checks #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);

>>> tb/sv/swmf_checker.sv
// Checker that predicts and compares the median filter's results.
`timescale 1ns / 1ps
module swmf_checker import swmf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [15:0]            req_pixel_value,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [ROW_W-1:0]       rsp_out_row,
   input  logic [COL_OUT_W-1:0]   rsp_out_col,
   input  logic [15:0]            rsp_median_value,
   input  logic                   rsp_last_of_frame,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     errors,
   output int                     pending,
   output int                     medians_seen
);

   typedef struct packed {
      logic [ROW_W-1:0]     row;
      logic [COL_OUT_W-1:0] col;
      logic [15:0]          median;
      logic                 last;
   } median_result_type;

   median_result_type medians_due[$];

   logic [LW_W-1:0]  line_width;
   logic [FH_W-1:0]  frame_height;
   logic [RAD_W-1:0] radius;
   logic             wide_samples;
   int               pix_col;
   int               pix_row;
   // The last seven rows of the frame, indexed by row modulo seven.
   logic [15:0]      recent_rows [7][2048];

   function automatic logic [15:0] window_median(int row, int col, int span);
      logic [15:0] vals [49];
      logic [15:0] x;
      int          n;
      int          j;
      n = 0;
      for (int k = 0; k <= span; k++)
         for (int c = 0; c <= span; c++) begin
            vals[n] = recent_rows[(row - span + k) % 7][col - span + c];
            n++;
         end
      for (int i = 1; i < n; i++) begin
         x = vals[i];
         j = i;
         while (j > 0 && vals[j-1] > x) begin
            vals[j] = vals[j-1];
            j--;
         end
         vals[j] = x;
      end
      return vals[n/2];
   endfunction

   always @(posedge clock) begin
      int                w;
      int                h;
      int                span;
      logic [15:0]       px;
      median_result_type want;
      median_result_type got;
      if (reset) begin
         line_width   <= LINE_WIDTH_RESET;
         frame_height <= FRAME_HEIGHT_RESET;
         radius       <= RADIUS_RESET;
         wide_samples <= 1'b0;
         pix_col      = 0;
         pix_row      = 0;
         medians_due.delete();
         errors       <= 0;
         medians_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LINE_WIDTH:   line_width   <= csr_data[LW_W-1:0];
               CSR_FRAME_HEIGHT: frame_height <= csr_data[FH_W-1:0];
               CSR_RADIUS:       radius       <= csr_data[RAD_W-1:0];
               CSR_WIDE_SAMPLES: wide_samples <= csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            w = (line_width == 0) ? 1 : (line_width > 2048) ? 2048 : line_width;
            h = (frame_height == 0) ? 1 : (frame_height > 4096) ? 4096 : frame_height;
            span = 2 * radius;
            if (pix_col >= w) pix_col = 0;
            if (pix_row >= h) pix_row = 0;
            px = wide_samples ? req_pixel_value : {8'h00, req_pixel_value[7:0]};
            recent_rows[pix_row % 7][pix_col] = px;
            if (pix_row >= span && pix_col >= span) begin
               want.row    = ROW_W'(pix_row - int'(radius));
               want.col    = COL_OUT_W'(pix_col - int'(radius));
               want.median = window_median(pix_row, pix_col, span);
               want.last   = (pix_row == h - 1) && (pix_col == w - 1);
               medians_due.push_back(want);
            end
            pix_col = pix_col + 1;
            if (pix_col >= w) begin
               pix_col = 0;
               pix_row = pix_row + 1;
               if (pix_row >= h) pix_row = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got.row    = rsp_out_row;
            got.col    = rsp_out_col;
            got.median = rsp_median_value;
            got.last   = rsp_last_of_frame;
            medians_seen <= medians_seen + 1;
            if (medians_due.size() == 0) begin
               $display("%0t: unexpected result row=%0d col=%0d median=%h last=%b",
                        $time, got.row, got.col, got.median, got.last);
               errors <= errors + 1;
            end else begin
               want = medians_due.pop_front();
               if (got != want) begin
                  $display("%0t: mismatch expected row=%0d col=%0d median=%h last=%b",
                           $time, want.row, want.col, want.median, want.last);
                  $display("%0t:          actual   row=%0d col=%0d median=%h last=%b",
                           $time, got.row, got.col, got.median, got.last);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

   assign pending = medians_due.size();

endmodule

>>> tb/sv/tb_square_window_median_filter_top.sv
// Testbench top for the square window median filter: stimulus and verdict.
`timescale 1ns / 1ps
module tb_square_window_median_filter_top;
   import swmf_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [15:0]           req_pixel_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [ROW_W-1:0]      rsp_out_row;
   logic [COL_OUT_W-1:0]  rsp_out_col;
   logic [15:0]           rsp_median_value;
   logic                  rsp_last_of_frame;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    errors;
   int                    pending;
   int                    medians_seen;

   // 0: no idling, 1: sender gaps, 2: receiver stalls, 3: both at a low rate.
   int idle_mode;
   int pixels_sent;
   int frames_sent;
   int quiet_cycles;

   square_window_median_filter_top i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_pixel_value,
      .rsp_valid, .rsp_ready, .rsp_out_row, .rsp_out_col, .rsp_median_value,
      .rsp_last_of_frame, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   swmf_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_pixel_value,
      .rsp_valid, .rsp_ready, .rsp_out_row, .rsp_out_col, .rsp_median_value,
      .rsp_last_of_frame, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .errors, .pending, .medians_seen
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      case (idle_mode)
         2:       rsp_ready <= ($urandom_range(99) >= 62);
         3:       rsp_ready <= ($urandom_range(99) >= 6);
         default: rsp_ready <= 1'b1;
      endcase
   end

   // Watchdog: any cycle with a transaction on some channel resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_reg(csr_index_type idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic send_pixel(logic [15:0] value);
      int gap_pct;
      gap_pct = (idle_mode == 1) ? 62 : (idle_mode == 3) ? 6 : 0;
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= value;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   function automatic logic [15:0] random_pixel();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h00FF;
         default: return 16'($urandom());
      endcase
   endfunction

   // Waits until every median is back, plus the pipeline depth for pixels
   // that produce nothing, before registers may change.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic run_frame(int lw, int fh, int rad, int wide, int pattern);
      int w;
      int h;
      drain();
      write_reg(CSR_LINE_WIDTH, lw);
      write_reg(CSR_FRAME_HEIGHT, fh);
      write_reg(CSR_RADIUS, rad);
      write_reg(CSR_WIDE_SAMPLES, wide);
      csr_valid <= 1'b0;
      w = (lw == 0) ? 1 : (lw > 2048) ? 2048 : lw;
      h = (fh == 0) ? 1 : (fh > 4096) ? 4096 : fh;
      idle_mode = frames_sent % 4;
      for (int i = 0; i < w * h; i++) begin
         if (pattern) send_pixel(i[0] ? 16'hFFFF : (i[1] ? 16'h00FF : 16'h0000));
         else         send_pixel(random_pixel());
      end
      frames_sent++;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_pixel_value = '0;
      rsp_ready       = 1'b1;
      csr_valid       = 1'b0;
      csr_index       = CSR_LINE_WIDTH;
      csr_data        = '0;
      idle_mode       = 0;
      pixels_sent     = 0;
      frames_sent     = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames: extreme pixel values, both sample modes, zero
      // registers, radius zero and the largest radius.
      run_frame(5, 5, 1, 0, 1);
      run_frame(3, 3, 1, 1, 1);
      run_frame(0, 0, 0, 1, 0);
      run_frame(7, 2, 3, 1, 0);
      run_frame(2, 7, 3, 0, 0);
      run_frame(7, 7, 3, 1, 1);

      while (pixels_sent < 880)
         run_frame($urandom_range(1, 14), $urandom_range(1, 12), $urandom_range(0, 3),
                   $urandom_range(0, 1), 0);

      drain();
      $display("Sent %0d pixels in %0d frames over all radii and both sample widths;",
               pixels_sent, frames_sent);
      $display("checked %0d medians.", medians_seen);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
